### sv/ism_pkg.sv
package ism_pkg;

	// Store geometry
	localparam int STORE_DEPTH = 1048576;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Field widths
	localparam int MODE_W     = 2;
	localparam int POS_W      = 20;
	localparam int CHAR_W     = 8;
	localparam int OCC_W      = 16;
	localparam int STAT_W     = 3;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [3:0]        mask_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SNP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_LOADED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_READ     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_MERGED   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_LOW      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OCC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OCC = 2'd3;

	// A/C/G/T membership (A=8, C=4, G=2, T=1) for letters A..Z
	localparam mask_t LETTER_MASK [26] = '{
		4'd8, 4'd7, 4'd4, 4'd11, 4'd0, 4'd0, 4'd2, 4'd13, 4'd0, 4'd0, 4'd3, 4'd0, 4'd12,
		4'd15, 4'd0, 4'd0, 4'd0, 4'd10, 4'd6, 4'd1, 4'd0, 4'd14, 4'd9, 4'd0, 4'd5, 4'd0
	};

	// Uppercase IUPAC letter for each nonempty membership mask; $ for mask 0
	localparam char_t MASK_LETTER [16] = '{
		"$", "T", "G", "K", "C", "Y", "S", "B",
		"A", "W", "R", "D", "M", "H", "V", "N"
	};

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch item, start store read
		logic commit;   // write back, update counters, load result
	} ism_cmd_t;

	// Membership mask of one character, either case
	function automatic mask_t char_mask(input char_t c);
		char_t u;
		mask_t m;
		u = (c >= "a" && c <= "z") ? char_t'(c - 8'd32) : c;
		m = '0;
		if (u >= "A" && u <= "Z") begin
			m = LETTER_MASK[5'(u - "A")];
		end
		return m;
	endfunction

	// Store address of a genome position
	function automatic addr_t store_addr(input logic [POS_W-1:0] p);
		return ADDR_W'(32'(p) % STORE_DEPTH);
	endfunction

endpackage

### sv/ism_req_if.sv
interface ism_req_if import ism_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0]  position;
	char_t             base_char;
	char_t             ref_char;
	char_t             alt_char;
	logic [OCC_W-1:0]  occurrence;

	modport source (
		output valid, mode, position, base_char, ref_char, alt_char, occurrence,
		input  ready
	);
	modport sink (
		input  valid, mode, position, base_char, ref_char, alt_char, occurrence,
		output ready
	);
endinterface

### sv/ism_rsp_if.sv
interface ism_rsp_if import ism_pkg::*; ();
	logic              valid;
	logic              ready;
	char_t             stored_char;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  merged_count;
	logic [CNT_W-1:0]  low_count;
	logic [CNT_W-1:0]  high_count;

	modport source (
		output valid, stored_char, status, merged_count, low_count, high_count,
		input  ready
	);
	modport sink (
		input  valid, stored_char, status, merged_count, low_count, high_count,
		output ready
	);
endinterface

### sv/ism_ctrl.sv
module ism_ctrl import ism_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ism_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Handshake and commands
	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == ST_MERGE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result slot: filled on commit, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/ism_dp.sv
module ism_dp import ism_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ism_cmd_t              cmd,
	input  logic [MODE_W-1:0]     mode,
	input  logic [POS_W-1:0]      position,
	input  char_t                 base_char,
	input  char_t                 ref_char,
	input  char_t                 alt_char,
	input  logic [OCC_W-1:0]      occurrence,
	output char_t                 stored_char,
	output logic [STAT_W-1:0]     status,
	output logic [CNT_W-1:0]      merged_count,
	output logic [CNT_W-1:0]      low_count,
	output logic [CNT_W-1:0]      high_count
);

	// Configuration
	logic             min_on_q;
	logic [OCC_W-1:0] min_occ_q;
	logic             max_on_q;
	logic [OCC_W-1:0] max_occ_q;

	// Item in flight
	logic [MODE_W-1:0] mode_q;
	addr_t             addr_q;
	char_t             base_q;
	char_t             ref_q;
	char_t             alt_q;
	logic [OCC_W-1:0]  occ_q;

	// Store and its registered read
	char_t store_mem [STORE_DEPTH];
	char_t rd_data_q;

	// Counters and result
	logic [CNT_W-1:0]  merged_q;
	logic [CNT_W-1:0]  low_q;
	logic [CNT_W-1:0]  high_q;
	char_t             out_char_q;
	logic [STAT_W-1:0] out_stat_q;

	// Step decision
	logic              low_hit;
	logic              high_hit;
	logic              wr_en;
	char_t             wr_data;
	char_t             res_char;
	logic [STAT_W-1:0] res_stat;
	logic              inc_merged;
	logic              inc_low;
	logic              inc_high;
	mask_t             union_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_on_q  <= 1'b0;
			min_occ_q <= '0;
			max_on_q  <= 1'b0;
			max_occ_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_ON:  min_on_q  <= cfg_data[0];
				CFG_MIN_OCC: min_occ_q <= cfg_data[OCC_W-1:0];
				CFG_MAX_ON:  max_on_q  <= cfg_data[0];
				CFG_MAX_OCC: max_occ_q <= cfg_data[OCC_W-1:0];
				default: ;
			endcase
		end
	end

	// Latch the item on acceptance
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			addr_q <= store_addr(position);
			base_q <= base_char;
			ref_q  <= ref_char;
			alt_q  <= alt_char;
			occ_q  <= occurrence;
		end
	end

	// Store: read on acceptance, write back on commit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_data_q <= store_mem[store_addr(position)];
		end
		if (wr_en) begin
			store_mem[addr_q] <= wr_data;
		end
	end

	// Filters and merge
	assign low_hit    = min_on_q && (occ_q < min_occ_q);
	assign high_hit   = max_on_q && (occ_q > max_occ_q);
	assign union_mask = char_mask(rd_data_q) | char_mask(ref_q) | char_mask(alt_q);

	always_comb begin
		wr_en      = 1'b0;
		wr_data    = base_q;
		res_char   = rd_data_q;
		res_stat   = STAT_READ;
		inc_merged = 1'b0;
		inc_low    = 1'b0;
		inc_high   = 1'b0;
		case (mode_q)
			MODE_LOAD: begin
				wr_en    = cmd.commit;
				wr_data  = base_q;
				res_char = base_q;
				res_stat = STAT_LOADED;
			end
			MODE_SNP: begin
				if (low_hit) begin
					res_stat = STAT_LOW;
					inc_low  = cmd.commit;
				end else if (high_hit) begin
					wr_en    = cmd.commit;
					wr_data  = alt_q;
					res_char = alt_q;
					res_stat = STAT_REPLACED;
					inc_high = cmd.commit;
				end else begin
					wr_en      = cmd.commit;
					wr_data    = MASK_LETTER[union_mask];
					res_char   = MASK_LETTER[union_mask];
					res_stat   = STAT_MERGED;
					inc_merged = cmd.commit;
				end
			end
			default: begin
				res_stat = STAT_READ;
			end
		endcase
	end

	// Saturating counters; they change only on commit, with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merged_q <= '0;
			low_q    <= '0;
			high_q   <= '0;
		end else begin
			if (inc_merged && merged_q != '1) merged_q <= merged_q + 1'b1;
			if (inc_low && low_q != '1)       low_q    <= low_q + 1'b1;
			if (inc_high && high_q != '1)     high_q   <= high_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_char_q <= res_char;
			out_stat_q <= res_stat;
		end
	end

	assign stored_char  = out_char_q;
	assign status       = out_stat_q;
	assign merged_count = merged_q;
	assign low_count    = low_q;
	assign high_count   = high_q;

endmodule

### sv/iupac_snp_merge_store.sv
// Channel  Dir  Transaction
// req      in   one item: mode, position, base_char, ref_char, alt_char, occurrence
// rsp      out  one result: stored_char, status, merged/low/high counts
// cfg      in   register write: cfg_we, cfg_index, cfg_data
//
// Each item gets a registered store read, then the merge and write-back
// of the same entry in the single-port store; one item is in flight at a time.
// A new item is taken while the previous result waits in the output register;
// the write-back stalls only while that register is still full.
// Reset clears the counters, configuration and handshake state; the store
// itself is not cleared and an entry must be loaded before it is used.
module iupac_snp_merge_store import ism_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ism_req_if.sink               req,
	ism_rsp_if.source             rsp
);

	ism_cmd_t cmd;

	ism_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	ism_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.mode         (req.mode),
		.position     (req.position),
		.base_char    (req.base_char),
		.ref_char     (req.ref_char),
		.alt_char     (req.alt_char),
		.occurrence   (req.occurrence),
		.stored_char  (rsp.stored_char),
		.status       (rsp.status),
		.merged_count (rsp.merged_count),
		.low_count    (rsp.low_count),
		.high_count   (rsp.high_count)
	);

`ifndef SYNTHESIS
	// One item at a time: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while another is in flight");

	// A commit always presents a result next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("committed result not presented");

	// Never commit and accept in the same cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.capture))
		else $error("capture and commit overlap");

	// A dropped SNP result implies a nonzero drop counter
	a_low_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_LOW |-> rsp.low_count != '0)
		else $error("dropped SNP not counted");
`endif

endmodule
